>>> design/budgeted_ranked_test_selector_core_defines.svh
// Assertion macros for the selector modules; only brts_ctrl uses them.
// No dependencies; pulled in by `include where a module asserts.
`ifndef BUDGETED_RANKED_TEST_SELECTOR_CORE_DEFINES_SVH
`define BUDGETED_RANKED_TEST_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define BRTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/brts_pkg.sv
// Shared types, constants and the ranking compare of the selector.
// No dependencies.
package brts_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int ID_W          = 6;
    localparam int HITS_W        = 10;
    localparam int VAL_W         = 24;
    localparam int TOTAL_W       = 30;
    localparam int CNT_LIM_W     = 7;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COST_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUR_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0]  dur;
        logic [VAL_W-1:0]  cost;
        logic [HITS_W-1:0] hits;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic load_en;
        logic shift_en;
    } chain_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_WALK
    } state_t;

    function automatic logic ranks_before(input entry_t a, input entry_t b);
        logic r;
        if (a.hits != b.hits) begin
            r = (a.hits > b.hits);
        end else begin
            r = (a.cost < b.cost);
        end
        return r;
    endfunction

endpackage

>>> design/brts_cell.sv
// One slot of the sorted insertion chain.
// Depends on brts_pkg (entry_t, chain_ctl_t, ranks_before).
module brts_cell (
    input  logic                aclk,
    input  brts_pkg::chain_ctl_t ctl,
    input  logic                empty,
    input  brts_pkg::entry_t    new_entry,
    input  brts_pkg::entry_t    left_entry,
    input  logic                left_ins,
    input  brts_pkg::entry_t    right_entry,
    output brts_pkg::entry_t    entry,
    output logic                ins
);

    brts_pkg::entry_t entry_reg;
    brts_pkg::entry_t entry_next;

    assign ins   = empty || brts_pkg::ranks_before(new_entry, entry_reg);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        priority if (ctl.load_en) begin
            if (ins) begin
                entry_next = left_ins ? left_entry : new_entry;
            end
        end else if (ctl.shift_en) begin
            entry_next = right_entry;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> design/brts_chain.sv
// Row of insertion cells that keeps the loaded items in rank order.
// Depends on brts_pkg and brts_cell.
module brts_chain #(
    parameter int MAX_ITEMS = brts_pkg::MAX_ITEMS_DEF,
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  logic                 aclk,
    input  brts_pkg::chain_ctl_t ctl,
    input  logic [CNT_W-1:0]     count,
    input  brts_pkg::entry_t     new_entry,
    output brts_pkg::entry_t     head
);

    brts_pkg::entry_t entries [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] ins;

    genvar k;
    generate
        for (k = 0; k < MAX_ITEMS; k++) begin : g_cell
            brts_pkg::entry_t left_e;
            brts_pkg::entry_t right_e;
            logic             left_i;
            logic             empty;

            assign empty = (CNT_W'(k) >= count);

            if (k == 0) begin : g_first
                assign left_e = new_entry;
                assign left_i = 1'b0;
            end else begin : g_mid
                assign left_e = entries[k-1];
                assign left_i = ins[k-1];
            end

            if (k == MAX_ITEMS - 1) begin : g_last
                assign right_e = entries[k];
            end else begin : g_inner
                assign right_e = entries[k+1];
            end

            brts_cell u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .empty       (empty),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_ins    (left_i),
                .right_entry (right_e),
                .entry       (entries[k]),
                .ins         (ins[k])
            );
        end
    endgenerate

    assign head = entries[0];

endmodule

>>> design/brts_ctrl.sv
// Load control, greedy budget walk over the chain head and result register.
// Depends on brts_pkg and the assertion macro header.
`include "budgeted_ranked_test_selector_core_defines.svh"

module brts_ctrl #(
    parameter int MAX_ITEMS = brts_pkg::MAX_ITEMS_DEF,
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tlast,
    input  brts_pkg::entry_t                  head,
    input  logic [brts_pkg::VAL_W-1:0]        cost_limit,
    input  logic [brts_pkg::VAL_W-1:0]        dur_limit,
    input  logic [brts_pkg::CNT_LIM_W-1:0]    count_limit,
    output logic [CNT_W-1:0]                  count,
    output brts_pkg::chain_ctl_t              ctl,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [brts_pkg::ID_W-1:0]         m_id,
    output logic                              m_last
);

    localparam logic [brts_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

    brts_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CNT_W-1:0]                 idx_reg, idx_next;
    logic [CNT_W-1:0]                 pick_reg, pick_next;
    logic [brts_pkg::TOTAL_W-1:0]     cost_tot_reg, cost_tot_next;
    logic [brts_pkg::TOTAL_W-1:0]     dur_tot_reg, dur_tot_next;
    logic [brts_pkg::ID_W-1:0]        pend_reg, pend_next;
    logic                             have_pend_reg, have_pend_next;
    logic [brts_pkg::ID_W-1:0]        first_reg, first_next;
    logic                             m_valid_reg, m_valid_next;
    logic [brts_pkg::ID_W-1:0]        m_id_reg, m_id_next;
    logic                             m_last_reg, m_last_next;

    logic                             accept, out_free, walking, stop, sel, push;
    logic                             cost_ok, dur_ok;
    logic [brts_pkg::TOTAL_W:0]       cost_sum, dur_sum;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign walking  = (state_reg == brts_pkg::ST_WALK) && out_free;

    assign stop = (idx_reg == count_reg) ||
                  ((count_limit != '0) && (brts_pkg::CNT_LIM_W'(pick_reg) >= count_limit));

    assign cost_sum = {1'b0, cost_tot_reg} + (brts_pkg::TOTAL_W + 1)'(head.cost);
    assign dur_sum  = {1'b0, dur_tot_reg} + (brts_pkg::TOTAL_W + 1)'(head.dur);
    assign cost_ok  = (cost_limit == '0) ||
                      (cost_sum <= (brts_pkg::TOTAL_W + 1)'(cost_limit));
    assign dur_ok   = (dur_limit == '0) ||
                      (dur_sum <= (brts_pkg::TOTAL_W + 1)'(dur_limit));
    assign sel      = walking && !stop && cost_ok && dur_ok;
    assign push     = walking && (stop || (sel && have_pend_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            brts_pkg::ST_LOAD: if (accept && s_tlast) state_next = brts_pkg::ST_WALK;
            brts_pkg::ST_WALK: if (walking && stop) state_next = brts_pkg::ST_LOAD;
            default:           state_next = brts_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = 1'b0;
        ctl.load_en  = 1'b0;
        ctl.shift_en = 1'b0;
        unique case (state_reg)
            brts_pkg::ST_LOAD: begin
                s_tready    = 1'b1;
                ctl.load_en = accept && (count_reg < CNT_W'(MAX_ITEMS));
            end
            brts_pkg::ST_WALK: begin
                ctl.shift_en = walking && !stop;
            end
            default: ;
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        pick_next      = pick_reg;
        cost_tot_next  = cost_tot_reg;
        dur_tot_next   = dur_tot_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        first_next     = first_reg;
        m_id_next      = m_id_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        if (ctl.load_en) begin
            count_next = count_reg + 1'b1;
        end
        if (accept && s_tlast) begin
            idx_next       = '0;
            pick_next      = '0;
            cost_tot_next  = '0;
            dur_tot_next   = '0;
            have_pend_next = 1'b0;
        end
        if (walking && !stop) begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == '0) begin
                first_next = head.id;
            end
        end
        if (sel) begin
            pick_next      = pick_reg + 1'b1;
            pend_next      = head.id;
            have_pend_next = 1'b1;
            cost_tot_next  = cost_sum[brts_pkg::TOTAL_W] ? TOTAL_MAX
                                                         : cost_sum[brts_pkg::TOTAL_W-1:0];
            dur_tot_next   = dur_sum[brts_pkg::TOTAL_W] ? TOTAL_MAX
                                                        : dur_sum[brts_pkg::TOTAL_W-1:0];
        end
        if (walking && stop) begin
            count_next = '0;
        end
        if (push) begin
            m_valid_next = 1'b1;
            m_last_next  = stop;
            m_id_next    = (stop && !have_pend_reg) ? first_reg : pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= brts_pkg::ST_LOAD;
            count_reg     <= '0;
            idx_reg       <= '0;
            pick_reg      <= '0;
            cost_tot_reg  <= '0;
            dur_tot_reg   <= '0;
            have_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pick_reg      <= pick_next;
            cost_tot_reg  <= cost_tot_next;
            dur_tot_reg   <= dur_tot_next;
            have_pend_reg <= have_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        first_reg  <= first_next;
        m_id_reg   <= m_id_next;
        m_last_reg <= m_last_next;
    end

    assign count    = count_reg;
    assign m_tvalid = m_valid_reg;
    assign m_id     = m_id_reg;
    assign m_last   = m_last_reg;

    `BRTS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_ITEMS), "count over depth")
    `BRTS_ASSERT_NOW(a_pick_le_idx, aclk, aresetn, state_reg == brts_pkg::ST_WALK, pick_reg <= idx_reg, "more picks than visited")
    `BRTS_ASSERT_NOW(a_cost_budget, aclk, aresetn, (state_reg == brts_pkg::ST_WALK) && (cost_limit != '0), cost_tot_reg <= brts_pkg::TOTAL_W'(cost_limit), "cost total over budget")
    `BRTS_ASSERT_NEXT(a_run_end, aclk, aresetn, walking && stop, (state_reg == brts_pkg::ST_LOAD) && m_valid_reg && m_last_reg, "run end without last item")

endmodule

>>> design/budgeted_ranked_test_selector_core.sv
// Budgeted ranked selector: insertion chain of MAX_ITEMS cells plus walk control.
// Depends on brts_pkg, brts_chain, brts_cell and brts_ctrl.
//
// Use: write cost_limit, duration_limit and count_limit on the cfg port while idle.
// Stream candidate items on s_*, one per cycle; s_tlast marks the last item of a
// set. Each item enters the rank-ordered cell chain in the cycle it is accepted.
// Items beyond MAX_ITEMS in a set are dropped. After the last item, s_tready drops
// and the chain shifts its entries out toward the head, one per cycle, through the
// budget check. Selected ids leave on m_* in rank order; m_tlast marks the final
// one. If no item fits, the top-ranked id is sent alone with m_tlast set.
// The walk runs one step per cycle and freezes while m_tvalid waits on m_tready.
// Loading of the next set starts once the walk ends; the last result may still sit
// in the output register then. Reset clears the limits, counters and the output.
module budgeted_ranked_test_selector_core #(
    parameter int MAX_ITEMS = brts_pkg::MAX_ITEMS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [brts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brts_pkg::VAL_W-1:0]       cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,  // item_id, hit_count, item_cost, item_duration
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,  // chosen_id, zero pad
    output logic                             m_tlast
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [brts_pkg::VAL_W-1:0]     cost_limit_reg, cost_limit_next;
    logic [brts_pkg::VAL_W-1:0]     dur_limit_reg, dur_limit_next;
    logic [brts_pkg::CNT_LIM_W-1:0] cnt_limit_reg, cnt_limit_next;

    brts_pkg::chain_ctl_t           ctl;
    brts_pkg::entry_t               head;
    logic [CNT_W-1:0]               count;
    logic [brts_pkg::ID_W-1:0]      m_id;

    always_comb begin
        cost_limit_next = cost_limit_reg;
        dur_limit_next  = dur_limit_reg;
        cnt_limit_next  = cnt_limit_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                brts_pkg::REG_COST_LIMIT:  cost_limit_next = cfg_data;
                brts_pkg::REG_DUR_LIMIT:   dur_limit_next  = cfg_data;
                brts_pkg::REG_COUNT_LIMIT: cnt_limit_next  = cfg_data[brts_pkg::CNT_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_limit_reg <= '0;
            dur_limit_reg  <= '0;
            cnt_limit_reg  <= '0;
        end else begin
            cost_limit_reg <= cost_limit_next;
            dur_limit_reg  <= dur_limit_next;
            cnt_limit_reg  <= cnt_limit_next;
        end
    end

    brts_chain #(
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W)
    ) u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .count     (count),
        .new_entry (brts_pkg::entry_t'(s_tdata)),
        .head      (head)
    );

    brts_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tlast     (s_tlast),
        .head        (head),
        .cost_limit  (cost_limit_reg),
        .dur_limit   (dur_limit_reg),
        .count_limit (cnt_limit_reg),
        .count       (count),
        .ctl         (ctl),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_id        (m_id),
        .m_last      (m_tlast)
    );

    assign m_tdata = {2'b00, m_id};

endmodule

>>> dv/tb_budgeted_ranked_test_selector_core.sv
`timescale 1ns / 1ps
// Testbench for budgeted_ranked_test_selector_core: streams candidate sets, predicts the
// ranked greedy pick under the cost, duration and count budgets, and checks every chosen id.
// Depends on brts_pkg and the core RTL.
module tb_budgeted_ranked_test_selector_core;

    typedef struct packed {
        logic [brts_pkg::ID_W-1:0] id;
        logic                      last;
    } pick_t;

    localparam int                          SET_CAP   = 64;
    localparam logic [brts_pkg::VAL_W-1:0]  VAL_MAX   = '1;
    localparam longint                      TOTAL_CAP =
        (longint'(1) << brts_pkg::TOTAL_W) - 1;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [brts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [brts_pkg::VAL_W-1:0]     cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic [63:0]                    s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tready  = 1'b0;
    logic                           s_tready;
    logic                           m_tvalid;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;

    brts_pkg::entry_t               held [SET_CAP];
    int                             held_n = 0;
    logic [brts_pkg::VAL_W-1:0]     cost_lim = '0;
    logic [brts_pkg::VAL_W-1:0]     dur_lim = '0;
    logic [brts_pkg::CNT_LIM_W-1:0] count_lim = '0;
    pick_t                          picks_due [$];
    int                             mismatches = 0;
    int                             s_idle_pct = 24;
    int                             r_idle_pct = 75;

    budgeted_ranked_test_selector_core #(
        .MAX_ITEMS(SET_CAP)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic bit outranks(input brts_pkg::entry_t a, input brts_pkg::entry_t b);
        if (a.hits != b.hits) begin
            return a.hits > b.hits;
        end
        return a.cost < b.cost;
    endfunction

    function automatic longint sat_total(input longint t, input longint v);
        return (t + v > TOTAL_CAP) ? TOTAL_CAP : t + v;
    endfunction

    // rank the held set stably, walk it greedily and queue the chosen ids
    function automatic void predict_selection();
        int               order [SET_CAP];
        int               i;
        int               j;
        int               picked;
        longint           ctot;
        longint           dtot;
        brts_pkg::entry_t e;
        pick_t            p;
        pick_t            run [$];
        for (i = 0; i < held_n; i++) begin
            j = i;
            while (j > 0 && outranks(held[i], held[order[j-1]])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        ctot = 0;
        dtot = 0;
        picked = 0;
        for (i = 0; i < held_n; i++) begin
            e = held[order[i]];
            if (count_lim != 0 && picked >= count_lim) break;
            if (cost_lim != 0 && ctot + e.cost > cost_lim) continue;
            if (dur_lim != 0 && dtot + e.dur > dur_lim) continue;
            p.id = e.id;
            p.last = 1'b0;
            run.push_back(p);
            ctot = sat_total(ctot, e.cost);
            dtot = sat_total(dtot, e.dur);
            picked++;
        end
        if (run.size() == 0) begin
            p.id = held[order[0]].id;
            p.last = 1'b1;
            run.push_back(p);
        end else begin
            run[run.size()-1].last = 1'b1;
        end
        foreach (run[k]) picks_due.push_back(run[k]);
        held_n = 0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_pick();
        pick_t want;
        if (picks_due.size() == 0) begin
            report_mismatch("chosen_id with nothing pending",
                            m_tdata[brts_pkg::ID_W-1:0], -1);
        end else begin
            want = picks_due.pop_front();
            if (m_tdata[brts_pkg::ID_W-1:0] != want.id)
                report_mismatch("chosen_id", m_tdata[brts_pkg::ID_W-1:0], want.id);
            if (m_tlast != want.last)
                report_mismatch("end_of_list", m_tlast, want.last);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (held_n < SET_CAP) begin
                    held[held_n] = brts_pkg::entry_t'(s_tdata);
                    held_n++;
                end
                if (s_tlast) predict_selection();
            end
            if (m_tvalid && m_tready) check_pick();
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= r_idle_pct);
    end

    function automatic brts_pkg::entry_t mk_entry(input int id, input int hits, input int cost,
                                                  input int dur);
        brts_pkg::entry_t e;
        e.id = brts_pkg::ID_W'(id);
        e.hits = brts_pkg::HITS_W'(hits);
        e.cost = brts_pkg::VAL_W'(cost);
        e.dur = brts_pkg::VAL_W'(dur);
        return e;
    endfunction

    function automatic logic [brts_pkg::VAL_W-1:0] rand_amount();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return VAL_MAX;
            2: return brts_pkg::VAL_W'($urandom_range(0, 3) * 256);
            3, 4: return brts_pkg::VAL_W'($urandom());
            default: return brts_pkg::VAL_W'($urandom_range(0, 20000));
        endcase
    endfunction

    function automatic logic [brts_pkg::VAL_W-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return VAL_MAX;
            2: return brts_pkg::VAL_W'($urandom());
            default: return brts_pkg::VAL_W'($urandom_range(500, 40000));
        endcase
    endfunction

    function automatic brts_pkg::entry_t rand_entry();
        brts_pkg::entry_t e;
        e.id = brts_pkg::ID_W'($urandom_range(0, 63));
        case ($urandom_range(0, 7))
            0: e.hits = '0;
            1: e.hits = '1;
            2, 3, 4: e.hits = brts_pkg::HITS_W'($urandom_range(5, 7));
            default: e.hits = brts_pkg::HITS_W'($urandom_range(0, 1023));
        endcase
        e.cost = rand_amount();
        e.dur = rand_amount();
        return e;
    endfunction

    // call at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input brts_pkg::entry_t e, input logic last);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < s_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= e;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_limits(input logic [brts_pkg::VAL_W-1:0] cl,
                              input logic [brts_pkg::VAL_W-1:0] dl,
                              input logic [brts_pkg::CNT_LIM_W-1:0] nl);
        cfg_wr_en <= 1'b1;
        cfg_index <= brts_pkg::REG_COST_LIMIT;
        cfg_data <= cl;
        @(negedge aclk);
        cfg_index <= brts_pkg::REG_DUR_LIMIT;
        cfg_data <= dl;
        @(negedge aclk);
        cfg_index <= brts_pkg::REG_COUNT_LIMIT;
        cfg_data <= brts_pkg::VAL_W'(nl);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cost_lim = cl;
        dur_lim = dl;
        count_lim = nl;
    endtask

    // drop valid, wait out every pending id, then let the walk wind down
    task automatic settle();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        while (picks_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic test_single_item();
        set_limits('0, '0, '0);
        send_item(mk_entry(63, 1023, VAL_MAX, VAL_MAX), 1'b1);
        settle();
    endtask

    task automatic test_rank_ties();
        send_item(mk_entry(5, 300, 500, 10), 1'b0);
        send_item(mk_entry(6, 300, 200, 10), 1'b0);
        send_item(mk_entry(7, 300, 500, 20), 1'b0);
        send_item(mk_entry(8, 1023, 0, 0), 1'b0);
        send_item(mk_entry(0, 0, 0, 0), 1'b0);
        send_item(mk_entry(9, 300, 200, 30), 1'b1);
        settle();
    endtask

    task automatic test_budget_skip();
        set_limits(brts_pkg::VAL_W'(1000), brts_pkg::VAL_W'(3000), brts_pkg::CNT_LIM_W'(3));
        send_item(mk_entry(1, 900, 1500, 100), 1'b0);
        send_item(mk_entry(2, 800, 600, 2000), 1'b0);
        send_item(mk_entry(3, 700, 500, 500), 1'b0);
        send_item(mk_entry(4, 600, 300, 900), 1'b0);
        send_item(mk_entry(5, 500, 100, 50), 1'b0);
        send_item(mk_entry(11, 400, 0, 0), 1'b1);
        settle();
    endtask

    task automatic test_nothing_fits();
        set_limits(brts_pkg::VAL_W'(1), VAL_MAX, '0);
        send_item(mk_entry(10, 5, 256, 0), 1'b0);
        send_item(mk_entry(11, 9, 512, 0), 1'b0);
        send_item(mk_entry(12, 9, 257, 1), 1'b1);
        settle();
    endtask

    task automatic test_count_above_set();
        set_limits(VAL_MAX, VAL_MAX, brts_pkg::CNT_LIM_W'(SET_CAP));
        send_item(mk_entry(20, 1, VAL_MAX, 7), 1'b0);
        send_item(mk_entry(21, 1, VAL_MAX, VAL_MAX), 1'b0);
        send_item(mk_entry(22, 0, 0, 0), 1'b1);
        settle();
    endtask

    task automatic test_store_full();
        int k;
        set_limits('0, '0, '0);
        for (k = 0; k < SET_CAP + 4; k++) send_item(rand_entry(), k == SET_CAP + 3);
        settle();
    endtask

    task automatic test_random(input int n_items, input logic [brts_pkg::VAL_W-1:0] cl,
                               input logic [brts_pkg::VAL_W-1:0] dl,
                               input logic [brts_pkg::CNT_LIM_W-1:0] nl);
        int sent;
        int size;
        int k;
        int r;
        set_limits(cl, dl, nl);
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 19);
            if (r == 0) size = $urandom_range(SET_CAP + 1, SET_CAP + 3);
            else if (r == 1) size = $urandom_range(20, SET_CAP);
            else size = $urandom_range(1, 10);
            for (k = 0; k < size; k++) send_item(rand_entry(), k == size - 1);
            sent += size;
        end
        settle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_single_item();
        test_rank_ties();
        test_budget_skip();
        test_nothing_fits();
        test_count_above_set();
        test_store_full();
        test_random(60, rand_limit(), rand_limit(),
                    brts_pkg::CNT_LIM_W'($urandom_range(0, 8)));

        s_idle_pct = 75;
        r_idle_pct = 24;
        test_random(60, VAL_MAX, VAL_MAX, brts_pkg::CNT_LIM_W'(SET_CAP));
        test_random(60, rand_limit(), '0, brts_pkg::CNT_LIM_W'(1));

        s_idle_pct = 0;
        r_idle_pct = 0;
        test_random(60, '0, rand_limit(), brts_pkg::CNT_LIM_W'($urandom_range(0, SET_CAP)));
        test_random(60, rand_limit(), rand_limit(),
                    brts_pkg::CNT_LIM_W'($urandom_range(0, 6)));

        settle();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && picks_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> budgeted_ranked_test_selector_core.f
+incdir+design
design/brts_pkg.sv
design/brts_cell.sv
design/brts_chain.sv
design/brts_ctrl.sv
design/budgeted_ranked_test_selector_core.sv
dv/tb_budgeted_ranked_test_selector_core.sv
